// ===== rtl/grw_pkg.sv =====
package grw_pkg;

    localparam int COORD_W = 10;
    localparam int COST_W  = 48;
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    localparam logic [1:0] OP_PLACE   = 2'd0;
    localparam logic [1:0] OP_REROUTE = 2'd1;
    localparam logic [1:0] OP_SCORE   = 2'd2;

    typedef enum logic [1:0] {
        WM_SCORE  = 2'd0,
        WM_ADD    = 2'd1,
        WM_REMOVE = 2'd2
    } walk_mode_t;

    typedef enum logic [1:0] {
        CS_ACC  = 2'd0,
        CS_BEST = 2'd1,
        CS_ZERO = 2'd2
    } cost_sel_t;

    // candidate families in search order
    typedef enum logic [2:0] {
        K_1A  = 3'd0,
        K_1B  = 3'd1,
        K_2X  = 3'd2,
        K_2Y  = 3'd3,
        K_3H  = 3'd4,
        K_3V  = 3'd5,
        K_END = 3'd6
    } cand_kind_t;

    typedef struct packed {
        logic [1:0]                n;
        logic [2:0][COORD_W-1:0]   bx;
        logic [2:0][COORD_W-1:0]   by;
    } route_t;

    typedef struct packed {
        logic       load;
        logic       clr_en;
        logic       walk_init;
        logic       walk_cand;
        walk_mode_t mode;
        logic       ex_en;
        logic       ac_en;
        logic       best_from_acc;
        logic       cand_first;
        logic       cand_next;
        logic       cand_take;
        logic       out_load;
        cost_sel_t  cost_sel;
    } cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic       walk_done;
        logic       cand_end;
        logic       cand_valid;
        logic [1:0] op;
        logic       collinear;
        logic       out_free;
    } status_t;

endpackage

// ===== rtl/grw_ram.sv =====
module grw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/grw_datapath.sv =====
module grw_datapath import grw_pkg::*; #(
    parameter int GRID_WIDTH  = 1024,
    parameter int GRID_HEIGHT = 1024,
    parameter int COUNT_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic [1:0]         opcode,
    input  logic [COORD_W-1:0] start_x,
    input  logic [COORD_W-1:0] start_y,
    input  logic [COORD_W-1:0] end_x,
    input  logic [COORD_W-1:0] end_y,
    input  logic [1:0]         bend_count,
    input  logic [COORD_W-1:0] first_bend_x,
    input  logic [COORD_W-1:0] first_bend_y,
    input  logic [COORD_W-1:0] second_bend_x,
    input  logic [COORD_W-1:0] second_bend_y,
    input  logic [COORD_W-1:0] third_bend_x,
    input  logic [COORD_W-1:0] third_bend_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         new_bend_count,
    output logic [COORD_W-1:0] new_first_x,
    output logic [COORD_W-1:0] new_first_y,
    output logic [COORD_W-1:0] new_second_x,
    output logic [COORD_W-1:0] new_second_y,
    output logic [COORD_W-1:0] new_third_x,
    output logic [COORD_W-1:0] new_third_y,
    output logic [COST_W-1:0]  route_cost
);

    localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // item registers
    logic [1:0]         op_reg;
    logic [COORD_W-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    route_t             best_reg;
    logic [COST_W-1:0]  best_cost_reg;

    // walker
    logic [COORD_W-1:0] wx_reg, wy_reg;
    logic [1:0]         wi_reg;
    walk_mode_t         mode_reg;
    logic               sel_cand_reg;
    logic [COST_W-1:0]  acc_reg, sq_reg;

    // candidate enumeration
    cand_kind_t         kind_reg, kind_next;
    logic [COORD_W-1:0] xm_reg, ym_reg, xm_next, ym_next;

    // output word
    logic               out_valid_reg;
    route_t             out_route_reg;
    logic [COST_W-1:0]  out_cost_reg;

    logic [AW-1:0]      clr_reg;

    logic [COORD_W-1:0] xmin, xmax, ymin, ymax;
    logic [COORD_W:0]   xm1, ym1, xmax_w, ymax_w;
    route_t             cand, wr;
    logic [COORD_W-1:0] tx_a [4];
    logic [COORD_W-1:0] ty_a [4];
    logic               found;
    logic [1:0]         leg;
    logic [COORD_W-1:0] tx, ty, wx_step, wy_step;
    logic               in_range;
    logic [AW-1:0]      cell_addr;
    logic [COUNT_BITS-1:0] rd_data, mod_val;
    logic [63:0]        prod;
    logic [COST_W-1:0]  sq_val;
    logic [COST_W:0]    sum;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    route_t             in_route;

    assign xmin   = (sx_reg < ex_reg) ? sx_reg : ex_reg;
    assign xmax   = (sx_reg < ex_reg) ? ex_reg : sx_reg;
    assign ymin   = (sy_reg < ey_reg) ? sy_reg : ey_reg;
    assign ymax   = (sy_reg < ey_reg) ? ey_reg : sy_reg;
    assign xm1    = {1'b0, xm_reg} + 1'b1;
    assign ym1    = {1'b0, ym_reg} + 1'b1;
    assign xmax_w = {1'b0, xmax};
    assign ymax_w = {1'b0, ymax};

    // candidate route for the current enumeration position
    always_comb
    begin
        cand = '0;
        unique case (kind_reg)
            K_1A:
            begin
                cand.n = 2'd1; cand.bx[0] = ex_reg; cand.by[0] = sy_reg;
            end
            K_1B:
            begin
                cand.n = 2'd1; cand.bx[0] = sx_reg; cand.by[0] = ey_reg;
            end
            K_2X:
            begin
                cand.n = 2'd2;
                cand.bx[0] = xm_reg; cand.by[0] = sy_reg;
                cand.bx[1] = xm_reg; cand.by[1] = ey_reg;
            end
            K_2Y:
            begin
                cand.n = 2'd2;
                cand.bx[0] = sx_reg; cand.by[0] = ym_reg;
                cand.bx[1] = ex_reg; cand.by[1] = ym_reg;
            end
            K_3H:
            begin
                cand.n = 2'd3;
                cand.bx[0] = xm_reg; cand.by[0] = sy_reg;
                cand.bx[1] = xm_reg; cand.by[1] = ym_reg;
                cand.bx[2] = ex_reg; cand.by[2] = ym_reg;
            end
            K_3V:
            begin
                cand.n = 2'd3;
                cand.bx[0] = sx_reg; cand.by[0] = ym_reg;
                cand.bx[1] = xm_reg; cand.by[1] = ym_reg;
                cand.bx[2] = xm_reg; cand.by[2] = ey_reg;
            end
            default:
            begin
                cand = '0;
            end
        endcase
    end

    // next enumeration position
    always_comb
    begin
        kind_next = kind_reg;
        xm_next   = xm_reg;
        ym_next   = ym_reg;
        unique case (kind_reg)
            K_1A:
            begin
                kind_next = K_1B;
            end
            K_1B:
            begin
                kind_next = K_2X;
                xm_next   = xmin + 1'b1;
            end
            K_2X:
            begin
                if (xm1 < xmax_w)
                begin
                    xm_next = xm1[COORD_W-1:0];
                end
                else
                begin
                    kind_next = K_2Y;
                    ym_next   = ymin + 1'b1;
                end
            end
            K_2Y:
            begin
                if (ym1 < ymax_w)
                begin
                    ym_next = ym1[COORD_W-1:0];
                end
                else
                begin
                    kind_next = K_3H;
                    xm_next   = xmin + 1'b1;
                    ym_next   = ymin + 1'b1;
                end
            end
            K_3H, K_3V:
            begin
                if (ym1 < ymax_w)
                begin
                    ym_next = ym1[COORD_W-1:0];
                end
                else
                begin
                    ym_next = ymin + 1'b1;
                    if (xm1 < xmax_w)
                    begin
                        xm_next = xm1[COORD_W-1:0];
                    end
                    else
                    begin
                        kind_next = (kind_reg == K_3H) ? K_3V : K_END;
                        xm_next   = xmin + 1'b1;
                    end
                end
            end
            default:
            begin
                kind_next = K_END;
            end
        endcase
    end

    // leg targets of the route being walked
    assign wr = sel_cand_reg ? cand : best_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            tx_a[j] = (2'(j) < wr.n) ? wr.bx[j] : ex_reg;
            ty_a[j] = (2'(j) < wr.n) ? wr.by[j] : ey_reg;
        end
        tx_a[3] = ex_reg;
        ty_a[3] = ey_reg;
    end

    // first leg from the current one that still has cells to cover
    always_comb
    begin
        found = 1'b0;
        leg   = 2'd0;
        for (int j = 0; j < 4; j++)
        begin
            if (!found && 2'(j) >= wi_reg && 2'(j) <= wr.n &&
                (tx_a[j] != wx_reg || ty_a[j] != wy_reg))
            begin
                found = 1'b1;
                leg   = 2'(j);
            end
        end
    end

    assign tx = tx_a[leg];
    assign ty = ty_a[leg];

    // x first, then y
    always_comb
    begin
        wx_step = wx_reg;
        wy_step = wy_reg;
        if (wx_reg < tx)
        begin
            wx_step = wx_reg + 1'b1;
        end
        else if (wx_reg > tx)
        begin
            wx_step = wx_reg - 1'b1;
        end
        else if (wy_reg < ty)
        begin
            wy_step = wy_reg + 1'b1;
        end
        else
        begin
            wy_step = wy_reg - 1'b1;
        end
    end

    assign in_range  = (32'(wx_reg) < 32'(GRID_WIDTH)) && (32'(wy_reg) < 32'(GRID_HEIGHT));
    assign cell_addr = AW'(32'(wy_reg) * 32'(GRID_WIDTH) + 32'(wx_reg));

    always_comb
    begin
        if (mode_reg == WM_ADD)
        begin
            mod_val = (rd_data != COUNT_MAX) ? rd_data + 1'b1 : rd_data;
        end
        else
        begin
            mod_val = (rd_data != '0) ? rd_data - 1'b1 : rd_data;
        end
    end

    assign prod   = 64'(rd_data) * 64'(rd_data);
    assign sq_val = !in_range ? '0 :
                    (prod[63:COST_W] != '0) ? COST_MAX : prod[COST_W-1:0];
    assign sum    = {1'b0, acc_reg} + {1'b0, sq_reg};

    assign ram_we    = cmd.clr_en || (cmd.ex_en && mode_reg != WM_SCORE && in_range);
    assign ram_waddr = cmd.clr_en ? clr_reg : cell_addr;
    assign ram_wdata = cmd.clr_en ? '0 : mod_val;

    grw_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(DEPTH)
    ) u_grid (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(cell_addr),
        .rdata(rd_data)
    );

    always_comb
    begin
        in_route       = '0;
        in_route.n     = bend_count;
        if (bend_count > 2'd0)
        begin
            in_route.bx[0] = first_bend_x;
            in_route.by[0] = first_bend_y;
        end
        if (bend_count > 2'd1)
        begin
            in_route.bx[1] = second_bend_x;
            in_route.by[1] = second_bend_y;
        end
        if (bend_count > 2'd2)
        begin
            in_route.bx[2] = third_bend_x;
            in_route.by[2] = third_bend_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_en)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode;
            sx_reg   <= start_x;
            sy_reg   <= start_y;
            ex_reg   <= end_x;
            ey_reg   <= end_y;
            best_reg <= in_route;
        end
        if (cmd.walk_init)
        begin
            wx_reg       <= sx_reg;
            wy_reg       <= sy_reg;
            wi_reg       <= 2'd0;
            acc_reg      <= '0;
            mode_reg     <= cmd.mode;
            sel_cand_reg <= cmd.walk_cand;
        end
        if (cmd.ex_en)
        begin
            sq_reg <= sq_val;
        end
        if (cmd.ac_en)
        begin
            if (mode_reg == WM_SCORE)
            begin
                acc_reg <= sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
            end
            if (found)
            begin
                wx_reg <= wx_step;
                wy_reg <= wy_step;
                wi_reg <= leg;
            end
        end
        if (cmd.best_from_acc)
        begin
            best_cost_reg <= acc_reg;
        end
        if (cmd.cand_take && acc_reg < best_cost_reg)
        begin
            best_cost_reg <= acc_reg;
            best_reg      <= cand;
        end
        if (cmd.cand_first)
        begin
            kind_reg <= K_1A;
        end
        else if (cmd.cand_next)
        begin
            kind_reg <= kind_next;
            xm_reg   <= xm_next;
            ym_reg   <= ym_next;
        end
        if (cmd.out_load)
        begin
            out_route_reg <= best_reg;
            unique case (cmd.cost_sel)
                CS_ACC:  out_cost_reg <= acc_reg;
                CS_BEST: out_cost_reg <= best_cost_reg;
                default: out_cost_reg <= '0;
            endcase
        end
    end

    always_comb
    begin
        status.clr_last   = (clr_reg == AW'(DEPTH - 1));
        status.walk_done  = !found;
        status.cand_end   = (kind_reg == K_END);
        unique case (kind_reg)
            K_1A, K_1B: status.cand_valid = 1'b1;
            K_2X:       status.cand_valid = (xm_reg < xmax);
            K_2Y:       status.cand_valid = (ym_reg < ymax);
            K_3H, K_3V: status.cand_valid = (xm_reg < xmax) && (ym_reg < ymax);
            default:    status.cand_valid = 1'b0;
        endcase
        status.op         = op_reg;
        status.collinear  = (sx_reg == ex_reg) || (sy_reg == ey_reg);
        status.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid      = out_valid_reg;
    assign new_bend_count = out_route_reg.n;
    assign new_first_x    = out_route_reg.bx[0];
    assign new_first_y    = out_route_reg.by[0];
    assign new_second_x   = out_route_reg.bx[1];
    assign new_second_y   = out_route_reg.by[1];
    assign new_third_x    = out_route_reg.bx[2];
    assign new_third_y    = out_route_reg.by[2];
    assign route_cost     = out_cost_reg;

endmodule

// ===== rtl/grw_ctrl.sv =====
module grw_ctrl import grw_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [8:0] {
        S_CLR  = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_DEC  = 9'b000000100,
        S_WRD  = 9'b000001000,
        S_WEX  = 9'b000010000,
        S_WAC  = 9'b000100000,
        S_NEXT = 9'b001000000,
        S_CCHK = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    typedef enum logic [2:0] {
        T_PLACE_ADD = 3'd0,
        T_ECHO      = 3'd1,
        T_RR_REMOVE = 3'd2,
        T_RR_SCORE  = 3'd3,
        T_CAND      = 3'd4,
        T_RR_ADD    = 3'd5
    } task_t;

    state_t    state_reg, state_next;
    task_t     task_reg, task_next;
    cost_sel_t csel_reg, csel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            task_reg  <= T_ECHO;
            csel_reg  <= CS_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            task_reg  <= task_next;
            csel_reg  <= csel_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        task_next    = task_reg;
        csel_next    = csel_reg;
        cmd          = '0;
        cmd.mode     = WM_SCORE;
        cmd.cost_sel = csel_reg;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clr_en = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                priority if (status.op == OP_PLACE)
                begin
                    cmd.walk_init = 1'b1;
                    cmd.mode      = WM_ADD;
                    task_next     = T_PLACE_ADD;
                    state_next    = S_WRD;
                end
                else if (status.op == OP_SCORE ||
                         (status.op == OP_REROUTE && status.collinear))
                begin
                    cmd.walk_init = 1'b1;
                    task_next     = T_ECHO;
                    csel_next     = CS_ACC;
                    state_next    = S_WRD;
                end
                else if (status.op == OP_REROUTE)
                begin
                    cmd.walk_init = 1'b1;
                    cmd.mode      = WM_REMOVE;
                    task_next     = T_RR_REMOVE;
                    state_next    = S_WRD;
                end
                else
                begin
                    csel_next  = CS_ZERO;
                    state_next = S_DONE;
                end
            end
            S_WRD:
            begin
                state_next = S_WEX;
            end
            S_WEX:
            begin
                cmd.ex_en  = 1'b1;
                state_next = S_WAC;
            end
            S_WAC:
            begin
                cmd.ac_en  = 1'b1;
                state_next = status.walk_done ? S_NEXT : S_WRD;
            end
            S_NEXT:
            begin
                unique case (task_reg)
                    T_PLACE_ADD:
                    begin
                        cmd.walk_init = 1'b1;
                        task_next     = T_ECHO;
                        csel_next     = CS_ACC;
                        state_next    = S_WRD;
                    end
                    T_RR_REMOVE:
                    begin
                        cmd.walk_init = 1'b1;
                        task_next     = T_RR_SCORE;
                        state_next    = S_WRD;
                    end
                    T_RR_SCORE:
                    begin
                        cmd.best_from_acc = 1'b1;
                        cmd.cand_first    = 1'b1;
                        state_next        = S_CCHK;
                    end
                    T_CAND:
                    begin
                        cmd.cand_take = 1'b1;
                        cmd.cand_next = 1'b1;
                        state_next    = S_CCHK;
                    end
                    T_RR_ADD:
                    begin
                        csel_next  = CS_BEST;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_CCHK:
            begin
                priority if (status.cand_end)
                begin
                    cmd.walk_init = 1'b1;
                    cmd.mode      = WM_ADD;
                    task_next     = T_RR_ADD;
                    state_next    = S_WRD;
                end
                else if (status.cand_valid)
                begin
                    cmd.walk_init = 1'b1;
                    cmd.walk_cand = 1'b1;
                    task_next     = T_CAND;
                    state_next    = S_WRD;
                end
                else
                begin
                    cmd.cand_next = 1'b1;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
    end

endmodule

// ===== rtl/grid_wire_rerouter.sv =====
// grid_wire_rerouter: occupancy grid with route place, score and reroute
//
// input channel: in_valid / in_stall carry one wire word (opcode, endpoints,
// current route of up to three bends). output channel: out_valid / out_stall
// carry one result word per input word (route and its cost).
// a word is taken on a rising edge with valid high and stall low.
// one word is worked at a time: accept, decode, then any walk passes, with each
// visited cell through the grid ram read, square or update and accumulate
// states and each pass ending in a next-task state, then output load. score
// takes one pass over the route, place two (add, score); a collinear reroute
// only scores, others walk the route twice (remove, score), then each
// candidate of w+h+1 cells for endpoints w columns and h rows apart, 2 +
// (w-1) + (h-1) + 2*(w-1)*(h-1) candidates, each followed by a check state,
// then add the winner; a box one cell thin idles there per skipped position.
// the output register parts the channels: a new word is taken while a result
// still waits, and the finished result waits in its last state until the
// output register is free, so out_stall holds the output word and that result.
// after reset all GRID_WIDTH*GRID_HEIGHT cells of the grid ram are cleared,
// one cell a cycle, with in_stall high the whole time.
module grid_wire_rerouter import grw_pkg::*; #(
    parameter int GRID_WIDTH  = 1024,
    parameter int GRID_HEIGHT = 1024,
    parameter int COUNT_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic [COORD_W-1:0] start_x,
    input  logic [COORD_W-1:0] start_y,
    input  logic [COORD_W-1:0] end_x,
    input  logic [COORD_W-1:0] end_y,
    input  logic [1:0]         bend_count,
    input  logic [COORD_W-1:0] first_bend_x,
    input  logic [COORD_W-1:0] first_bend_y,
    input  logic [COORD_W-1:0] second_bend_x,
    input  logic [COORD_W-1:0] second_bend_y,
    input  logic [COORD_W-1:0] third_bend_x,
    input  logic [COORD_W-1:0] third_bend_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         new_bend_count,
    output logic [COORD_W-1:0] new_first_x,
    output logic [COORD_W-1:0] new_first_y,
    output logic [COORD_W-1:0] new_second_x,
    output logic [COORD_W-1:0] new_second_y,
    output logic [COORD_W-1:0] new_third_x,
    output logic [COORD_W-1:0] new_third_y,
    output logic [COST_W-1:0]  route_cost
);

    // command and status between sequencer and walker datapath
    cmd_t    cmd;
    status_t status;

    // sequencer: clear sweep, opcode decode, walk passes, candidate search
    grw_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath: grid ram, route walker, cost accumulator, candidate counters
    grw_datapath #(
        .GRID_WIDTH (GRID_WIDTH),
        .GRID_HEIGHT(GRID_HEIGHT),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .opcode        (opcode),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .bend_count    (bend_count),
        .first_bend_x  (first_bend_x),
        .first_bend_y  (first_bend_y),
        .second_bend_x (second_bend_x),
        .second_bend_y (second_bend_y),
        .third_bend_x  (third_bend_x),
        .third_bend_y  (third_bend_y),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .new_bend_count(new_bend_count),
        .new_first_x   (new_first_x),
        .new_first_y   (new_first_y),
        .new_second_x  (new_second_x),
        .new_second_y  (new_second_y),
        .new_third_x   (new_third_x),
        .new_third_y   (new_third_y),
        .route_cost    (route_cost)
    );

endmodule

// ===== rtl/grw_checker.sv =====
module grw_checker import grw_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [COST_W-1:0] route_cost
);

    // held output word stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    a_cost_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(route_cost))
        else $error("route_cost changed while stalled");

    // one word in flight: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word taken while busy");

    // a result appears as the block returns to idle
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall && $past(in_stall))
        else $error("result without finished word");

endmodule

bind grid_wire_rerouter grw_checker u_grw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .route_cost(route_cost)
);

// ===== tb/sv/tb_grid_wire_rerouter.sv =====
module tb_grid_wire_rerouter;
    import grw_pkg::*;

    // run limit: it covers the grid clear after reset, and the reroutes here use
    // boxes of at most about 20 by 20 cells
    localparam int unsigned RUN_LIMIT = 40_000_000;
    localparam int GRID_W = 1024;
    localparam int unsigned CNT_MAX = 65535;
    localparam logic [1:0] OP_NONE = 2'd3;   // unused opcode, echoes the route

    typedef struct {
        int unsigned n;
        int unsigned bx[3];
        int unsigned by[3];
    } path_t;

    typedef struct {
        logic [1:0]         n;
        logic [COORD_W-1:0] bx[3];
        logic [COORD_W-1:0] by[3];
        logic [COST_W-1:0]  cost;
    } route_word_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         opcode;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [1:0]         bend_count;
    logic [COORD_W-1:0] first_bend_x;
    logic [COORD_W-1:0] first_bend_y;
    logic [COORD_W-1:0] second_bend_x;
    logic [COORD_W-1:0] second_bend_y;
    logic [COORD_W-1:0] third_bend_x;
    logic [COORD_W-1:0] third_bend_y;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         new_bend_count;
    logic [COORD_W-1:0] new_first_x;
    logic [COORD_W-1:0] new_first_y;
    logic [COORD_W-1:0] new_second_x;
    logic [COORD_W-1:0] new_second_y;
    logic [COORD_W-1:0] new_third_x;
    logic [COORD_W-1:0] new_third_y;
    logic [COST_W-1:0]  route_cost;

    grid_wire_rerouter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .bend_count    (bend_count),
        .first_bend_x  (first_bend_x),
        .first_bend_y  (first_bend_y),
        .second_bend_x (second_bend_x),
        .second_bend_y (second_bend_y),
        .third_bend_x  (third_bend_x),
        .third_bend_y  (third_bend_y),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .new_bend_count(new_bend_count),
        .new_first_x   (new_first_x),
        .new_first_y   (new_first_y),
        .new_second_x  (new_second_x),
        .new_second_y  (new_second_y),
        .new_third_x   (new_third_x),
        .new_third_y   (new_third_y),
        .route_cost    (route_cost)
    );

    // sparse mirror of the occupancy grid, key is y*width+x
    int unsigned occupancy[int unsigned];
    route_word_t routes_due[$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    // current wire endpoints, shared by the route walker
    int unsigned wsx, wsy, wex, wey;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------- grid predictor ----------------

    function automatic int unsigned cell_count(int unsigned x, int unsigned y);
        int unsigned k;
        k = y * GRID_W + x;
        return occupancy.exists(k) ? occupancy[k] : 0;
    endfunction

    // mode: score, add one, or remove one at one cell
    function automatic logic [63:0] touch_cell(int unsigned x, int unsigned y,
                                               walk_mode_t mode, logic [63:0] acc);
        int unsigned k;
        int unsigned c;
        logic [63:0] s;
        k = y * GRID_W + x;
        c = cell_count(x, y);
        if (mode == WM_SCORE) begin
            s = acc + 64'(c) * 64'(c);
            return (s > 64'(COST_MAX)) ? 64'(COST_MAX) : s;
        end
        if (mode == WM_ADD && c < CNT_MAX)
            occupancy[k] = c + 1;
        else if (mode == WM_REMOVE && c > 0)
            occupancy[k] = c - 1;
        return acc;
    endfunction

    // walk start -> bends -> end, each leg x first then y
    function automatic logic [63:0] walk_route(path_t p, walk_mode_t mode);
        int unsigned x, y, tx, ty;
        logic [63:0] acc;
        x = wsx;
        y = wsy;
        acc = touch_cell(x, y, mode, 64'd0);
        for (int unsigned i = 0; i <= p.n; i++) begin
            tx = (i < p.n) ? p.bx[i] : wex;
            ty = (i < p.n) ? p.by[i] : wey;
            while (x < tx) begin x++; acc = touch_cell(x, y, mode, acc); end
            while (x > tx) begin x--; acc = touch_cell(x, y, mode, acc); end
            while (y < ty) begin y++; acc = touch_cell(x, y, mode, acc); end
            while (y > ty) begin y--; acc = touch_cell(x, y, mode, acc); end
        end
        return acc;
    endfunction

    function automatic path_t make_path(int unsigned n, int unsigned x0, int unsigned y0,
                                        int unsigned x1, int unsigned y1,
                                        int unsigned x2, int unsigned y2);
        path_t p;
        p.n = n;
        p.bx = '{x0, x1, x2};
        p.by = '{y0, y1, y2};
        return p;
    endfunction

    // keep a candidate only when strictly cheaper
    function automatic void try_path(path_t c, ref path_t best, ref logic [63:0] best_cost);
        logic [63:0] v;
        v = walk_route(c, WM_SCORE);
        if (v < best_cost) begin
            best_cost = v;
            best = c;
        end
    endfunction

    function automatic logic [63:0] reroute_cheapest(ref path_t best);
        int unsigned x_lo, x_hi, y_lo, y_hi;
        logic [63:0] best_cost;
        void'(walk_route(best, WM_REMOVE));
        best_cost = walk_route(best, WM_SCORE);
        x_lo = (wsx < wex) ? wsx : wex;
        x_hi = (wsx < wex) ? wex : wsx;
        y_lo = (wsy < wey) ? wsy : wey;
        y_hi = (wsy < wey) ? wey : wsy;
        try_path(make_path(1, wex, wsy, 0, 0, 0, 0), best, best_cost);
        try_path(make_path(1, wsx, wey, 0, 0, 0, 0), best, best_cost);
        for (int unsigned xm = x_lo + 1; xm < x_hi; xm++)
            try_path(make_path(2, xm, wsy, xm, wey, 0, 0), best, best_cost);
        for (int unsigned ym = y_lo + 1; ym < y_hi; ym++)
            try_path(make_path(2, wsx, ym, wex, ym, 0, 0), best, best_cost);
        for (int unsigned xm = x_lo + 1; xm < x_hi; xm++)
            for (int unsigned ym = y_lo + 1; ym < y_hi; ym++)
                try_path(make_path(3, xm, wsy, xm, ym, wex, ym), best, best_cost);
        for (int unsigned xm = x_lo + 1; xm < x_hi; xm++)
            for (int unsigned ym = y_lo + 1; ym < y_hi; ym++)
                try_path(make_path(3, wsx, ym, xm, ym, xm, wey), best, best_cost);
        void'(walk_route(best, WM_ADD));
        return best_cost;
    endfunction

    function automatic route_word_t predict_route(logic [1:0] op, path_t p);
        route_word_t r;
        logic [63:0] cost;
        cost = 64'd0;
        // bends beyond the count are not part of the route
        for (int unsigned i = p.n; i < 3; i++) begin
            p.bx[i] = 0;
            p.by[i] = 0;
        end
        if (op == OP_PLACE) begin
            void'(walk_route(p, WM_ADD));
            cost = walk_route(p, WM_SCORE);
        end else if (op == OP_REROUTE) begin
            if (wsx == wex || wsy == wey)
                cost = walk_route(p, WM_SCORE);
            else
                cost = reroute_cheapest(p);
        end else if (op == OP_SCORE) begin
            cost = walk_route(p, WM_SCORE);
        end
        r.n = p.n[1:0];
        for (int i = 0; i < 3; i++) begin
            r.bx[i] = p.bx[i][COORD_W-1:0];
            r.by[i] = p.by[i][COORD_W-1:0];
        end
        r.cost = cost[COST_W-1:0];
        return r;
    endfunction

    // ---------------- driving ----------------

    // called at a falling edge, returns at a falling edge after the word is taken
    task automatic send_wire(logic [1:0] op, int unsigned sx, int unsigned sy,
                             int unsigned ex, int unsigned ey, path_t p);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        start_x       <= sx[COORD_W-1:0];
        start_y       <= sy[COORD_W-1:0];
        end_x         <= ex[COORD_W-1:0];
        end_y         <= ey[COORD_W-1:0];
        bend_count    <= p.n[1:0];
        first_bend_x  <= p.bx[0][COORD_W-1:0];
        first_bend_y  <= p.by[0][COORD_W-1:0];
        second_bend_x <= p.bx[1][COORD_W-1:0];
        second_bend_y <= p.by[1][COORD_W-1:0];
        third_bend_x  <= p.bx[2][COORD_W-1:0];
        third_bend_y  <= p.by[2][COORD_W-1:0];
        forever begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        wsx = sx;
        wsy = sy;
        wex = ex;
        wey = ey;
        routes_due.push_back(predict_route(op, p));
        burst_left--;
        @(negedge clk);
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        while (routes_due.size() != 0)
            @(negedge clk);
    endtask

    // receiver stall: phases of no stall, random stall and long stall runs
    int unsigned stall_phase = 0;
    int unsigned stall_mode = 0;
    int unsigned stall_run = 0;
    always @(negedge clk) begin
        if (stall_phase == 0) begin
            stall_phase = $urandom_range(20, 200);
            stall_mode = $urandom_range(0, 2);
        end
        stall_phase--;
        if (stall_mode == 0) begin
            out_stall <= 1'b0;
        end else if (stall_mode == 1) begin
            out_stall <= ($urandom_range(0, 1) == 1);
        end else begin
            if (stall_run == 0)
                stall_run = $urandom_range(1, 24);
            stall_run--;
            out_stall <= (stall_run > 4);
        end
    end

    // ---------------- result checking ----------------

    always @(posedge clk) begin
        route_word_t exp_r;
        if (rst_n && out_valid && !out_stall) begin
            if (routes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: n=%0d cost=%0d",
                             new_bend_count, route_cost);
            end else begin
                exp_r = routes_due.pop_front();
                if (new_bend_count !== exp_r.n || new_first_x !== exp_r.bx[0]
                    || new_first_y !== exp_r.by[0] || new_second_x !== exp_r.bx[1]
                    || new_second_y !== exp_r.by[1] || new_third_x !== exp_r.bx[2]
                    || new_third_y !== exp_r.by[2] || route_cost !== exp_r.cost) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("route mismatch exp n=%0d (%0d,%0d) (%0d,%0d) (%0d,%0d) cost=%0d",
                                 exp_r.n, exp_r.bx[0], exp_r.by[0], exp_r.bx[1],
                                 exp_r.by[1], exp_r.bx[2], exp_r.by[2], exp_r.cost);
                        $display("               got n=%0d (%0d,%0d) (%0d,%0d) (%0d,%0d) cost=%0d",
                                 new_bend_count, new_first_x, new_first_y, new_second_x,
                                 new_second_y, new_third_x, new_third_y, route_cost);
                    end
                end
            end
        end
    end

    // ---------------- tests ----------------

    function automatic int unsigned near(int unsigned base, int unsigned span);
        int unsigned v;
        v = base + $urandom_range(0, span);
        return (v > 1023) ? 1023 : v;
    endfunction

    // grid extremes, place and score, long routes and opcode three
    task automatic test_extremes();
        send_wire(OP_PLACE, 0, 0, 1023, 1023, make_path(0, 0, 0, 0, 0, 0, 0));
        send_wire(OP_SCORE, 1023, 1023, 0, 0, make_path(3, 1023, 0, 0, 1023, 1023, 1023));
        send_wire(OP_PLACE, 1023, 0, 0, 1023, make_path(2, 0, 0, 1023, 1023, 0, 0));
        send_wire(OP_SCORE, 0, 0, 1023, 1023, make_path(1, 0, 1023, 5, 5, 7, 7));
        // unused bend fields are driven but ignored
        send_wire(OP_NONE, 12, 34, 56, 78, make_path(1, 1023, 1023, 1023, 1023, 1023, 1023));
        send_wire(OP_SCORE, 0, 0, 0, 0, make_path(0, 1023, 1023, 1023, 1023, 1023, 1023));
        send_wire(OP_NONE, 1023, 1023, 1023, 1023, make_path(3, 1, 2, 3, 4, 5, 6));
    endtask

    // collinear wires, ties on an empty area, congestion that forces a detour
    task automatic test_reroute();
        send_wire(OP_REROUTE, 100, 100, 108, 100, make_path(0, 0, 0, 0, 0, 0, 0));
        send_wire(OP_REROUTE, 100, 100, 100, 90, make_path(1, 100, 95, 0, 0, 0, 0));
        send_wire(OP_REROUTE, 200, 200, 206, 205, make_path(0, 0, 0, 0, 0, 0, 0));
        send_wire(OP_REROUTE, 206, 205, 200, 200, make_path(1, 200, 205, 0, 0, 0, 0));
        pause_until_drained();
        // stack wires on the x-first path so the reroute must move away
        for (int i = 0; i < 3; i++)
            send_wire(OP_PLACE, 300, 300, 306, 306, make_path(0, 0, 0, 0, 0, 0, 0));
        send_wire(OP_REROUTE, 300, 300, 306, 306, make_path(0, 0, 0, 0, 0, 0, 0));
        send_wire(OP_PLACE, 303, 298, 303, 308, make_path(0, 0, 0, 0, 0, 0, 0));
        send_wire(OP_REROUTE, 301, 306, 305, 299, make_path(2, 303, 306, 303, 299, 0, 0));
        send_wire(OP_REROUTE, 300, 300, 306, 306, make_path(3, 302, 300, 302, 304, 306, 304));
        send_wire(OP_SCORE, 300, 300, 306, 306, make_path(0, 0, 0, 0, 0, 0, 0));
        // two wide boxes
        send_wire(OP_REROUTE, 1003, 1003, 1023, 1023, make_path(0, 0, 0, 0, 0, 0, 0));
        send_wire(OP_REROUTE, 0, 20, 20, 0, make_path(1, 0, 0, 0, 0, 0, 0));
    endtask

    // well-formed wires in crowded windows, plus some stray far bends
    task automatic test_random(int unsigned count);
        logic [1:0] op;
        int unsigned bx0, by0, sx, sy, ex, ey, n;
        int unsigned px[3];
        int unsigned py[3];
        for (int unsigned k = 0; k < count; k++) begin
            if (k % 12 == 0) begin
                bx0 = $urandom_range(0, 9) == 0 ? ($urandom_range(0, 1) ? 0 : 1016)
                                                : $urandom_range(0, 1016);
                by0 = $urandom_range(0, 9) == 0 ? ($urandom_range(0, 1) ? 0 : 1016)
                                                : $urandom_range(0, 1016);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: op = OP_PLACE;
                4, 5, 6:    op = OP_REROUTE;
                7, 8:       op = OP_SCORE;
                default:    op = OP_NONE;
            endcase
            sx = near(bx0, 7);
            sy = near(by0, 7);
            ex = near(bx0, 7);
            ey = near(by0, 7);
            n = $urandom_range(0, 3);
            for (int i = 0; i < 3; i++) begin
                if ($urandom_range(0, 15) == 0) begin
                    px[i] = $urandom_range(0, 1023);
                    py[i] = $urandom_range(0, 1023);
                end else begin
                    px[i] = near(bx0, 7);
                    py[i] = near(by0, 7);
                end
            end
            send_wire(op, sx, sy, ex, ey, make_path(n, px[0], py[0], px[1], py[1],
                                                    px[2], py[2]));
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_PLACE;
        start_x = '0;
        start_y = '0;
        end_x = '0;
        end_y = '0;
        bend_count = '0;
        first_bend_x = '0;
        first_bend_y = '0;
        second_bend_x = '0;
        second_bend_y = '0;
        third_bend_x = '0;
        third_bend_y = '0;
        out_stall = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_reroute();
        test_random(80);

        in_valid <= 1'b0;
        while (routes_due.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
